### rtl/core/mcfc_pkg.sv
// ---------------------------------------------------------------------------
// mcfc_pkg
// Shared constants, types and helpers of the MIMO complex FIR channel unit.
// ---------------------------------------------------------------------------
package mcfc_pkg;

    localparam int P_MAX_TAPS     = 256;
    localparam int P_MAX_RX       = 4;
    localparam int P_MAX_TX       = 4;
    localparam int P_MAX_DELAY    = 64;
    localparam int P_SAMPLE_WIDTH = 16;

    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int LIMIT_W   = 48;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_SAMPLE = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RX_COUNT  = 3'd0,
        CFG_TX_COUNT  = 3'd1,
        CFG_TAP_COUNT = 3'd2,
        CFG_DELAY     = 3'd3,
        CFG_GAIN      = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WAIT,
        S_MAC,
        S_DRAIN,
        S_ZERO
    } t_state;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

    function automatic int f_aw(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    function automatic int f_acc_w(input int sw, input int ntx, input int ntaps);
        return 2 * sw + 1 + f_aw(ntx * ntaps);
    endfunction

endpackage

### rtl/core/mcfc_in_if.sv
// ---------------------------------------------------------------------------
// mcfc_in_if
// Input channel: start, tap load and sample transactions.
// ---------------------------------------------------------------------------
interface mcfc_in_if #(
    parameter int SW = 16
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           op;
    logic [1:0]           rx_index;
    logic [1:0]           tx_index;
    logic [7:0]           tap_index;
    logic signed [SW-1:0] value_re;
    logic signed [SW-1:0] value_im;

    modport source (output valid, op, rx_index, tx_index, tap_index, value_re, value_im,
                    input ready);
    modport sink   (input valid, op, rx_index, tx_index, tap_index, value_re, value_im,
                    output ready);
endinterface

### rtl/core/mcfc_out_if.sv
// ---------------------------------------------------------------------------
// mcfc_out_if
// Output channel: one received sample per receive antenna.
// ---------------------------------------------------------------------------
interface mcfc_out_if #(
    parameter int SW = 16
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           out_antenna;
    logic signed [SW-1:0] out_re;
    logic signed [SW-1:0] out_im;
    logic                 saturated;
    logic                 last;

    modport source (output valid, out_antenna, out_re, out_im, saturated, last,
                    input ready);
    modport sink   (input valid, out_antenna, out_re, out_im, saturated, last,
                    output ready);
endinterface

### rtl/core/mcfc_ram.sv
// ---------------------------------------------------------------------------
// mcfc_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module mcfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [mcfc_pkg::f_aw(DEPTH)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                  i_wdata,
    input  logic [mcfc_pkg::f_aw(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                  o_rdata
);
    import mcfc_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/core/mcfc_mac.sv
// ---------------------------------------------------------------------------
// mcfc_mac
// Complex multiply-accumulate: registered products, then accumulation.
// ---------------------------------------------------------------------------
module mcfc_mac #(
    parameter int SW    = 16,
    parameter int ACC_W = 43
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  mcfc_pkg::t_mac_ctl       i_ctl,
    input  logic [2*SW-1:0]          i_x,
    input  logic [2*SW-1:0]          i_h,
    output logic                     o_valid,
    output logic signed [ACC_W-1:0]  o_acc_re,
    output logic signed [ACC_W-1:0]  o_acc_im
);
    import mcfc_pkg::*;

    t_mac_ctl               r_c1, r_c2;
    logic signed [SW-1:0]   xr, xi, hr, hi;
    logic signed [2*SW-1:0] r_p_rr, r_p_ii, r_p_ir, r_p_ri;
    logic signed [2*SW:0]   term_re, term_im;
    logic signed [ACC_W-1:0] n_acc_re, n_acc_im;

    assign xr = i_x[2*SW-1:SW];
    assign xi = i_x[SW-1:0];
    assign hr = i_h[2*SW-1:SW];
    assign hi = i_h[SW-1:0];

    always_comb begin
        term_re  = (2*SW+1)'(r_p_rr) - (2*SW+1)'(r_p_ii);
        term_im  = (2*SW+1)'(r_p_ir) + (2*SW+1)'(r_p_ri);
        n_acc_re = (r_c2.first ? '0 : o_acc_re) + ACC_W'(term_re);
        n_acc_im = (r_c2.first ? '0 : o_acc_im) + ACC_W'(term_im);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1    <= '0;
            r_c2    <= '0;
            o_valid <= 1'b0;
        end else begin
            r_c1    <= i_ctl;
            r_c2    <= r_c1;
            o_valid <= r_c2.valid & r_c2.last;
        end
        r_p_rr <= xr * hr;
        r_p_ii <= xi * hi;
        r_p_ir <= xi * hr;
        r_p_ri <= xr * hi;
        if (r_c2.valid) begin
            o_acc_re <= n_acc_re;
            o_acc_im <= n_acc_im;
        end
    end
endmodule

### rtl/core/mcfc_scale.sv
// ---------------------------------------------------------------------------
// mcfc_scale
// Gain scaling in split partial products, round half up and saturation.
// ---------------------------------------------------------------------------
module mcfc_scale #(
    parameter int SW    = 16,
    parameter int ACC_W = 43
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic signed [ACC_W-1:0]         i_acc_re,
    input  logic signed [ACC_W-1:0]         i_acc_im,
    input  logic [mcfc_pkg::GAIN_W-1:0]     i_gain,
    output logic                            o_valid,
    output logic signed [SW-1:0]            o_re,
    output logic signed [SW-1:0]            o_im,
    output logic                            o_sat
);
    import mcfc_pkg::*;

    localparam int EXT_W  = (ACC_W > LIMIT_W) ? ACC_W : LIMIT_W;
    localparam int HALF_W = LIMIT_W / 2;
    localparam int SHIFT  = SW - 1 + GAIN_FRAC;
    localparam int FULL_W = 66;
    localparam logic signed [EXT_W-1:0]  A_MAX = (EXT_W'(1) <<< (LIMIT_W - 1)) - 1;
    localparam logic signed [EXT_W-1:0]  A_MIN = -A_MAX - 1;
    localparam logic signed [FULL_W-1:0] V_MAX = (FULL_W'(1) <<< (SW - 1)) - 1;
    localparam logic signed [FULL_W-1:0] V_MIN = -V_MAX - 1;
    localparam logic signed [FULL_W-1:0] RND   = FULL_W'(1) <<< (SHIFT - 1);

    logic                              r_v1;
    logic signed [HALF_W+GAIN_W:0]     r_hi_re, r_hi_im;
    logic [HALF_W+GAIN_W-1:0]          r_lo_re, r_lo_im;
    logic signed [LIMIT_W-1:0]         a_re, a_im;
    logic signed [SW-1:0]              n_re, n_im;
    logic                              sat_re, sat_im;

    function automatic logic signed [LIMIT_W-1:0] f_lim(input logic signed [ACC_W-1:0] a);
        logic signed [EXT_W-1:0] e;
        e = EXT_W'(a);
        if (e > A_MAX) begin
            e = A_MAX;
        end else if (e < A_MIN) begin
            e = A_MIN;
        end
        return e[LIMIT_W-1:0];
    endfunction

    function automatic logic signed [SW:0] f_fin(input logic signed [HALF_W+GAIN_W:0] ph,
                                                 input logic [HALF_W+GAIN_W-1:0] pl);
        logic signed [FULL_W-1:0] f;
        logic signed [FULL_W-1:0] v;
        logic sat;
        f = (FULL_W'(ph) <<< HALF_W) + FULL_W'(pl) + RND;
        v = f >>> SHIFT;
        sat = 1'b0;
        if (v > V_MAX) begin
            v = V_MAX;
            sat = 1'b1;
        end else if (v < V_MIN) begin
            v = V_MIN;
            sat = 1'b1;
        end
        return {sat, v[SW-1:0]};
    endfunction

    assign a_re = f_lim(i_acc_re);
    assign a_im = f_lim(i_acc_im);
    assign {sat_re, n_re} = f_fin(r_hi_re, r_lo_re);
    assign {sat_im, n_im} = f_fin(r_hi_im, r_lo_im);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
        r_hi_re <= $signed(a_re[LIMIT_W-1:HALF_W]) * $signed({1'b0, i_gain});
        r_hi_im <= $signed(a_im[LIMIT_W-1:HALF_W]) * $signed({1'b0, i_gain});
        r_lo_re <= a_re[HALF_W-1:0] * i_gain;
        r_lo_im <= a_im[HALF_W-1:0] * i_gain;
        o_re    <= n_re;
        o_im    <= n_im;
        o_sat   <= sat_re | sat_im;
    end
endmodule

### rtl/core/mimo_complex_fir_channel_unit.sv
// ---------------------------------------------------------------------------
// mimo_complex_fir_channel_unit
// MIMO complex FIR channel: taps and sample history held in RAM, one shared
// complex MAC walks transmit antennas and taps for each receive antenna.
//
//   channel   dir  transaction
//   i_in      in   start / tap load / sample
//   o_out     out  one received sample per receive antenna
//   i_cfg_*   in   register write, index 0..4
//
// A sample closing a time step is worked off by the single MAC, reading one
// tap and one history entry per cycle while it accumulates.
// Reset and start run a clearing pass over the history RAM.
// A pending result holds only the next antenna's accumulation.
// ---------------------------------------------------------------------------
module mimo_complex_fir_channel_unit #(
    parameter int MAX_TAPS     = mcfc_pkg::P_MAX_TAPS,
    parameter int MAX_RX       = mcfc_pkg::P_MAX_RX,
    parameter int MAX_TX       = mcfc_pkg::P_MAX_TX,
    parameter int MAX_DELAY    = mcfc_pkg::P_MAX_DELAY,
    parameter int SAMPLE_WIDTH = mcfc_pkg::P_SAMPLE_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mcfc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mcfc_pkg::CFG_W-1:0]       i_cfg_data,
    mcfc_in_if.sink                          i_in,
    mcfc_out_if.source                       o_out
);
    import mcfc_pkg::*;

    localparam int SW       = SAMPLE_WIDTH;
    localparam int HIST_LEN = MAX_TAPS + MAX_DELAY;
    localparam int RX_AW    = f_aw(MAX_RX);
    localparam int TX_AW    = f_aw(MAX_TX);
    localparam int TAP_AW   = f_aw(MAX_TAPS);
    localparam int HIDX_W   = f_aw(HIST_LEN);
    localparam int RXC_W    = $clog2(MAX_RX + 1);
    localparam int TXC_W    = $clog2(MAX_TX + 1);
    localparam int TAPC_W   = $clog2(MAX_TAPS + 1);
    localparam int TADDR_W  = RX_AW + TX_AW + TAP_AW;
    localparam int HADDR_W  = TX_AW + HIDX_W;
    localparam int ACC_W    = f_acc_w(SW, MAX_TX, MAX_TAPS);

    t_state              r_state, n_state;
    logic [2:0]          r_rx_count, n_rx_count;
    logic [2:0]          r_tx_count, n_tx_count;
    logic [8:0]          r_tap_count, n_tap_count;
    logic [6:0]          r_delay, n_delay;
    logic [GAIN_W-1:0]   r_gain, n_gain;
    logic [RX_AW-1:0]    r_rx, n_rx;
    logic [TX_AW-1:0]    r_tx, n_tx;
    logic [TAP_AW-1:0]   r_tap, n_tap;
    logic [HIDX_W-1:0]   r_idx, n_idx;
    logic [HIDX_W-1:0]   r_ptr, n_ptr;
    logic [HADDR_W-1:0]  r_clr, n_clr;
    logic [TX_AW-1:0]    r_zt, n_zt;
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_out_ant, n_out_ant;
    logic signed [SW-1:0] r_out_re, n_out_re, r_out_im, n_out_im;
    logic                r_out_sat, n_out_sat, r_out_last, n_out_last;

    logic [RXC_W-1:0]    rxn;
    logic [TXC_W-1:0]    txn;
    logic [TAPC_W-1:0]   tapn;
    logic [HIDX_W-1:0]   dn, idx0, idx_dec, ptr_next;
    logic [RX_AW-1:0]    rx_last;
    logic [TX_AW-1:0]    tx_last;
    logic [TAP_AW-1:0]   tap_last;
    logic                in_acc, tap_we, hist_we;
    logic [TADDR_W-1:0]  tap_waddr, tap_raddr;
    logic [HADDR_W-1:0]  hist_waddr, hist_raddr;
    logic [2*SW-1:0]     hist_wdata, x_data, h_data;
    t_mac_ctl            mac_ctl;
    logic                acc_valid, res_valid, res_sat;
    logic signed [ACC_W-1:0] acc_re, acc_im;
    logic signed [SW-1:0] res_re, res_im;

    // effective register values
    always_comb begin
        if (r_rx_count == '0) begin
            rxn = RXC_W'(1);
        end else if (r_rx_count > MAX_RX) begin
            rxn = RXC_W'(MAX_RX);
        end else begin
            rxn = RXC_W'(r_rx_count);
        end
        if (r_tx_count == '0) begin
            txn = TXC_W'(1);
        end else if (r_tx_count > MAX_TX) begin
            txn = TXC_W'(MAX_TX);
        end else begin
            txn = TXC_W'(r_tx_count);
        end
        if (r_tap_count == '0) begin
            tapn = TAPC_W'(1);
        end else if (r_tap_count > MAX_TAPS) begin
            tapn = TAPC_W'(MAX_TAPS);
        end else begin
            tapn = TAPC_W'(r_tap_count);
        end
        if (r_delay > MAX_DELAY) begin
            dn = HIDX_W'(MAX_DELAY);
        end else begin
            dn = HIDX_W'(r_delay);
        end
        rx_last  = RX_AW'(rxn - 1'b1);
        tx_last  = TX_AW'(txn - 1'b1);
        tap_last = TAP_AW'(tapn - 1'b1);
        if (r_ptr >= dn) begin
            idx0 = r_ptr - dn;
        end else begin
            idx0 = HIDX_W'((HIDX_W+1)'(r_ptr) + (HIDX_W+1)'(HIST_LEN) - (HIDX_W+1)'(dn));
        end
        idx_dec  = (r_idx == '0) ? HIDX_W'(HIST_LEN - 1) : r_idx - 1'b1;
        ptr_next = (r_ptr == HIDX_W'(HIST_LEN - 1)) ? '0 : r_ptr + 1'b1;
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid & i_in.ready;

    assign tap_waddr  = {RX_AW'(i_in.rx_index), TX_AW'(i_in.tx_index),
                         TAP_AW'(i_in.tap_index)};
    assign tap_raddr  = {r_rx, r_tx, r_tap};
    assign hist_raddr = {r_tx, r_idx};

    always_comb begin
        n_state     = r_state;
        n_rx_count  = r_rx_count;
        n_tx_count  = r_tx_count;
        n_tap_count = r_tap_count;
        n_delay     = r_delay;
        n_gain      = r_gain;
        n_rx        = r_rx;
        n_tx        = r_tx;
        n_tap       = r_tap;
        n_idx       = r_idx;
        n_ptr       = r_ptr;
        n_clr       = r_clr;
        n_zt        = r_zt;
        n_out_valid = r_out_valid & ~o_out.ready;
        n_out_ant   = r_out_ant;
        n_out_re    = r_out_re;
        n_out_im    = r_out_im;
        n_out_sat   = r_out_sat;
        n_out_last  = r_out_last;
        tap_we      = 1'b0;
        hist_we     = 1'b0;
        hist_waddr  = {TX_AW'(i_in.tx_index), r_ptr};
        hist_wdata  = {i_in.value_re, i_in.value_im};
        mac_ctl     = '0;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RX_COUNT:  n_rx_count  = i_cfg_data[2:0];
                CFG_TX_COUNT:  n_tx_count  = i_cfg_data[2:0];
                CFG_TAP_COUNT: n_tap_count = i_cfg_data[8:0];
                CFG_DELAY:     n_delay     = i_cfg_data[6:0];
                CFG_GAIN:      n_gain      = i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_CLEAR: begin
                hist_we    = 1'b1;
                hist_waddr = r_clr;
                hist_wdata = '0;
                n_clr      = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in.op)
                        OP_START: begin
                            n_ptr   = '0;
                            n_clr   = '0;
                            n_state = S_CLEAR;
                        end
                        OP_LOAD: begin
                            tap_we = (i_in.rx_index < MAX_RX) && (i_in.tx_index < MAX_TX)
                                     && (i_in.tap_index < MAX_TAPS);
                        end
                        OP_SAMPLE: begin
                            if (i_in.tx_index < txn) begin
                                hist_we = 1'b1;
                                if (TX_AW'(i_in.tx_index) == tx_last) begin
                                    n_rx    = '0;
                                    n_state = S_WAIT;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WAIT: begin
                if (!r_out_valid) begin
                    n_tx    = '0;
                    n_tap   = '0;
                    n_idx   = idx0;
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                mac_ctl.valid = 1'b1;
                mac_ctl.first = (r_tx == '0) && (r_tap == '0);
                mac_ctl.last  = (r_tx == tx_last) && (r_tap == tap_last);
                if (r_tap == tap_last) begin
                    n_tap = '0;
                    n_idx = idx0;
                    n_tx  = r_tx + 1'b1;
                    if (r_tx == tx_last) begin
                        n_state = S_DRAIN;
                    end
                end else begin
                    n_tap = r_tap + 1'b1;
                    n_idx = idx_dec;
                end
            end
            S_DRAIN: begin
                if (res_valid) begin
                    n_out_valid = 1'b1;
                    n_out_ant   = 2'(r_rx);
                    n_out_re    = res_re;
                    n_out_im    = res_im;
                    n_out_sat   = res_sat;
                    n_out_last  = (r_rx == rx_last);
                    if (r_rx == rx_last) begin
                        n_ptr   = ptr_next;
                        n_zt    = '0;
                        n_state = S_ZERO;
                    end else begin
                        n_rx    = r_rx + 1'b1;
                        n_state = S_WAIT;
                    end
                end
            end
            S_ZERO: begin
                hist_we    = 1'b1;
                hist_waddr = {r_zt, r_ptr};
                hist_wdata = '0;
                n_zt       = r_zt + 1'b1;
                if (r_zt == TX_AW'(MAX_TX - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_rx_count  <= 3'd1;
            r_tx_count  <= 3'd1;
            r_tap_count <= 9'd1;
            r_delay     <= '0;
            r_gain      <= GAIN_W'(1 << GAIN_FRAC);
            r_rx        <= '0;
            r_tx        <= '0;
            r_tap       <= '0;
            r_idx       <= '0;
            r_ptr       <= '0;
            r_clr       <= '0;
            r_zt        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rx_count  <= n_rx_count;
            r_tx_count  <= n_tx_count;
            r_tap_count <= n_tap_count;
            r_delay     <= n_delay;
            r_gain      <= n_gain;
            r_rx        <= n_rx;
            r_tx        <= n_tx;
            r_tap       <= n_tap;
            r_idx       <= n_idx;
            r_ptr       <= n_ptr;
            r_clr       <= n_clr;
            r_zt        <= n_zt;
            r_out_valid <= n_out_valid;
        end
        r_out_ant  <= n_out_ant;
        r_out_re   <= n_out_re;
        r_out_im   <= n_out_im;
        r_out_sat  <= n_out_sat;
        r_out_last <= n_out_last;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_antenna = r_out_ant;
    assign o_out.out_re      = r_out_re;
    assign o_out.out_im      = r_out_im;
    assign o_out.saturated   = r_out_sat;
    assign o_out.last        = r_out_last;

    mcfc_ram #(
        .WIDTH (2 * SW),
        .DEPTH (1 << TADDR_W)
    ) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (tap_we),
        .i_waddr (tap_waddr),
        .i_wdata ({i_in.value_re, i_in.value_im}),
        .i_raddr (tap_raddr),
        .o_rdata (h_data)
    );

    mcfc_ram #(
        .WIDTH (2 * SW),
        .DEPTH (1 << HADDR_W)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (hist_raddr),
        .o_rdata (x_data)
    );

    mcfc_mac #(
        .SW    (SW),
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_x      (x_data),
        .i_h      (h_data),
        .o_valid  (acc_valid),
        .o_acc_re (acc_re),
        .o_acc_im (acc_im)
    );

    mcfc_scale #(
        .SW    (SW),
        .ACC_W (ACC_W)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (acc_valid),
        .i_acc_re (acc_re),
        .i_acc_im (acc_im),
        .i_gain   (r_gain),
        .o_valid  (res_valid),
        .o_re     (res_re),
        .o_im     (res_im),
        .o_sat    (res_sat)
    );

    a_no_hist_write_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> !hist_we)
        else $error("history written during accumulation");

    a_result_only_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (r_state == S_DRAIN))
        else $error("scaled result outside drain");

    a_drain_output_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && res_valid) |-> !r_out_valid)
        else $error("result would overwrite pending output");

    a_last_antenna: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && res_valid && r_rx == rx_last) |=> (r_state == S_ZERO))
        else $error("time step not closed after last antenna");
endmodule
